[rtl/utf8d_pkg.sv]
// Shared types, constants and lead byte decode for the UTF-8 byte stream decoder.
package utf8d_pkg;

    localparam int CpWidth  = 31;
    localparam int LenWidth = 3;

    localparam logic [2:0] LenInvalid = 3'd0;
    localparam logic [2:0] LenOne     = 3'd1;

    localparam logic [7:0] ByteAsciiMask = 8'h7F;
    localparam logic [5:0] ContPayloadW  = 6'h3F;
    localparam logic [1:0] ContTag       = 2'b10;

    typedef struct packed {
        logic [CpWidth-1:0]  acc;
        logic [LenWidth-1:0] remaining;
        logic [LenWidth-1:0] seq_len;
    } state_t;

    typedef struct packed {
        logic [CpWidth-1:0]  code_point;
        logic [LenWidth-1:0] seq_length;
        logic                decode_error;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t result;
    } step_t;

    // Sequence length from a lead byte; LenInvalid for a bad lead pattern.
    function automatic logic [LenWidth-1:0] lead_length(input logic [7:0] b);
        logic [LenWidth-1:0] n;
        n = LenInvalid;
        if ((b & 8'h80) == 8'h00)      n = 3'd1;
        else if ((b & 8'hE0) == 8'hC0) n = 3'd2;
        else if ((b & 8'hF0) == 8'hE0) n = 3'd3;
        else if ((b & 8'hF8) == 8'hF0) n = 3'd4;
        else if ((b & 8'hFC) == 8'hF8) n = 3'd5;
        else if ((b & 8'hFE) == 8'hFC) n = 3'd6;
        return n;
    endfunction

endpackage

[rtl/utf8d_if.sv]
// Valid/ready channel interfaces for raw bytes and decoded code points.
interface utf8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8d_cp_if;
    logic                              valid;
    logic                              ready;
    logic [utf8d_pkg::CpWidth-1:0]     code_point;
    logic [utf8d_pkg::LenWidth-1:0]    seq_length;
    logic                              decode_error;

    modport source (output valid, output code_point, output seq_length,
                    output decode_error, input ready);
    modport sink (input valid, input code_point, input seq_length,
                  input decode_error, output ready);
endinterface

[rtl/utf8d_step.sv]
// Next-state and result logic for one input byte.
module utf8d_step (
    input  utf8d_pkg::state_t st,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output utf8d_pkg::state_t st_next,
    output utf8d_pkg::step_t  step
);

    logic [utf8d_pkg::LenWidth-1:0] lead_n;
    logic [utf8d_pkg::CpWidth-1:0]  acc_shift;
    logic [utf8d_pkg::LenWidth-1:0] rem_dec;
    logic [7:0]                     lead_bits;

    assign lead_n    = utf8d_pkg::lead_length(data_byte);
    assign lead_bits = data_byte & (utf8d_pkg::ByteAsciiMask >> lead_n);
    assign acc_shift = {st.acc[utf8d_pkg::CpWidth-7:0], data_byte[5:0] & utf8d_pkg::ContPayloadW};
    assign rem_dec   = st.remaining - 3'd1;

    always_comb
    begin
        st_next = st;
        step    = '0;
        if (st.remaining == 3'd0)
        begin
            if (lead_n == utf8d_pkg::LenInvalid || data_byte == 8'h00)
            begin
                st_next                  = '0;
                step.emit                = 1'b1;
                step.result.decode_error = 1'b1;
            end
            else if (lead_n == utf8d_pkg::LenOne)
            begin
                st_next                = '0;
                step.emit              = 1'b1;
                step.result.code_point = {24'd0, data_byte[6:0]};
                step.result.seq_length = utf8d_pkg::LenOne;
            end
            else if (last_byte)
            begin
                st_next                  = '0;
                step.emit                = 1'b1;
                step.result.decode_error = 1'b1;
            end
            else
            begin
                st_next.acc       = {23'd0, lead_bits};
                st_next.remaining = lead_n - 3'd1;
                st_next.seq_len   = lead_n;
            end
        end
        else
        begin
            if (data_byte == 8'h00 || data_byte[7:6] != utf8d_pkg::ContTag)
            begin
                st_next                  = '0;
                step.emit                = 1'b1;
                step.result.decode_error = 1'b1;
            end
            else if (rem_dec == 3'd0)
            begin
                st_next                = '0;
                step.emit              = 1'b1;
                step.result.code_point = acc_shift;
                step.result.seq_length = st.seq_len;
            end
            else if (last_byte)
            begin
                st_next                  = '0;
                step.emit                = 1'b1;
                step.result.decode_error = 1'b1;
            end
            else
            begin
                st_next.acc       = acc_shift;
                st_next.remaining = rem_dec;
            end
        end
    end

endmodule

[rtl/utf8d_out_stage.sv]
// Result register between the decode logic and the output channel.
module utf8d_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  utf8d_pkg::result_t result,
    output logic               can_accept,
    utf8d_cp_if.source         cp_out
);

    logic               valid_reg;
    logic               valid_next;
    utf8d_pkg::result_t result_reg;

    assign can_accept = !valid_reg || cp_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (cp_out.ready)
            valid_next = 1'b0;
        if (load)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result;
    end

    assign cp_out.valid        = valid_reg;
    assign cp_out.code_point   = result_reg.code_point;
    assign cp_out.seq_length   = result_reg.seq_length;
    assign cp_out.decode_error = result_reg.decode_error;

endmodule

[rtl/utf8_byte_stream_decoder.sv]
// Top level of the streaming extended UTF-8 decoder.
// Decodes one byte per cycle unless the output stalls: each accepted request updates the sequence state
// (accumulator, bytes remaining, length) in the same cycle and, when a sequence
// completes or fails, loads one result into the output register, which is
// shown the next cycle. Sequences of 1 to 6 bytes yield code points up to 31
// bits; a bad lead, zero byte, bad continuation or a sequence cut short by
// last_byte yields one error result, and decoding restarts at the next byte.
// Input ready is held low only while the output register is full and stalled.
module utf8_byte_stream_decoder (
    input  logic       clk,
    input  logic       rst_n,
    utf8d_byte_if.sink byte_in,
    utf8d_cp_if.source cp_out
);

    utf8d_pkg::state_t state_reg;
    utf8d_pkg::state_t state_next;
    utf8d_pkg::step_t  step;
    logic              can_accept;
    logic              accept;

    assign byte_in.ready = can_accept;
    assign accept        = byte_in.valid && can_accept;

    utf8d_step u_step (
        .st        (state_reg),
        .data_byte (byte_in.data_byte),
        .last_byte (byte_in.last_byte),
        .st_next   (state_next),
        .step      (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    utf8d_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept && step.emit),
        .result     (step.result),
        .can_accept (can_accept),
        .cp_out     (cp_out)
    );

endmodule

[bench/utf8_byte_stream_decoder_tb.sv]
// Self-checking bench for the UTF-8 byte stream decoder: directed and random byte streams.
module utf8_byte_stream_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 2000;
    localparam int SettleCycles = 6;

    class cp_scoreboard;
        logic [utf8d_pkg::CpWidth-1:0]  acc;
        logic [utf8d_pkg::LenWidth-1:0] remaining;
        logic [utf8d_pkg::LenWidth-1:0] seq_len;
        utf8d_pkg::result_t             expected_points[$];
        int unsigned                    errors;

        function new();
            clear_sequence();
            errors = 0;
        endfunction

        function void clear_sequence();
            acc = '0;
            remaining = '0;
            seq_len = '0;
        endfunction

        function logic [utf8d_pkg::LenWidth-1:0] lead_bytes(logic [7:0] b);
            logic [utf8d_pkg::LenWidth-1:0] n;
            casez (b)
                8'b0???????: n = 3'd1;
                8'b110?????: n = 3'd2;
                8'b1110????: n = 3'd3;
                8'b11110???: n = 3'd4;
                8'b111110??: n = 3'd5;
                8'b1111110?: n = 3'd6;
                default:     n = utf8d_pkg::LenInvalid;
            endcase
            return n;
        endfunction

        function void push_error();
            utf8d_pkg::result_t r;
            r = '0;
            r.decode_error = 1'b1;
            clear_sequence();
            expected_points.push_back(r);
        endfunction

        function void push_point(logic [utf8d_pkg::CpWidth-1:0] cp,
                                 logic [utf8d_pkg::LenWidth-1:0] len);
            utf8d_pkg::result_t r;
            r.code_point = cp;
            r.seq_length = len;
            r.decode_error = 1'b0;
            clear_sequence();
            expected_points.push_back(r);
        endfunction

        // Advance the decode state by one accepted request.
        function void note_byte(logic [7:0] b, logic last);
            logic [utf8d_pkg::LenWidth-1:0] n;
            if (remaining == 0)
            begin
                n = lead_bytes(b);
                if (n == utf8d_pkg::LenInvalid || b == 8'h00)
                begin
                    push_error();
                end
                else if (n == utf8d_pkg::LenOne)
                begin
                    push_point(utf8d_pkg::CpWidth'(b[6:0]), utf8d_pkg::LenOne);
                end
                else if (last)
                begin
                    push_error();
                end
                else
                begin
                    acc = utf8d_pkg::CpWidth'(b & (8'h7F >> n));
                    remaining = n - 3'd1;
                    seq_len = n;
                end
            end
            else if (b[7:6] != utf8d_pkg::ContTag)
            begin
                push_error();
            end
            else
            begin
                acc = {acc[utf8d_pkg::CpWidth-7:0], b[5:0]};
                remaining = remaining - 3'd1;
                if (remaining == 0)
                    push_point(acc, seq_len);
                else if (last)
                    push_error();
            end
        endfunction

        function void check_point(utf8d_pkg::result_t got);
            utf8d_pkg::result_t want;
            if (expected_points.size() == 0)
            begin
                $error("unexpected result: code_point %h seq_length %0d decode_error %b",
                       got.code_point, got.seq_length, got.decode_error);
                errors++;
                return;
            end
            want = expected_points.pop_front();
            if (got.code_point !== want.code_point)
            begin
                $error("code_point: expected %h, actual %h", want.code_point, got.code_point);
                errors++;
            end
            if (got.seq_length !== want.seq_length)
            begin
                $error("seq_length: expected %0d, actual %0d", want.seq_length, got.seq_length);
                errors++;
            end
            if (got.decode_error !== want.decode_error)
            begin
                $error("decode_error: expected %b, actual %b",
                       want.decode_error, got.decode_error);
                errors++;
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    utf8d_byte_if byte_ch ();
    utf8d_cp_if   cp_ch ();

    cp_scoreboard sb;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    int unsigned  requests_sent;
    int unsigned  stall_cycles;

    utf8_byte_stream_decoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_ch),
        .cp_out  (cp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        sb.note_byte(b, last);
        requests_sent++;
    endtask

    // Mostly well-formed sequences; the rest truncated, broken or raw noise.
    task automatic send_random_sequence();
        int unsigned n;
        int unsigned kind;
        int unsigned stop;
        int unsigned k;
        logic [7:0]  seq_bytes [6];
        logic [7:0]  bad;
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            send_byte(8'($urandom), 1'($urandom));
            return;
        end
        n = $urandom_range(1, 6);
        if (n == 1)
            seq_bytes[0] = {1'b0, 7'($urandom)};
        else
            seq_bytes[0] = 8'(8'hFF << (8 - n)) | (8'($urandom) & (8'h7F >> n));
        for (k = 1; k < n; k++)
            seq_bytes[k] = {utf8d_pkg::ContTag, 6'($urandom)};
        stop = n;
        if (n > 1 && kind < 18)
        begin
            stop = $urandom_range(1, n - 1);
        end
        else if (n > 1 && kind < 26)
        begin
            bad = 8'($urandom);
            case ($urandom_range(3))
                0: bad = 8'h00;
                1: bad[7:6] = 2'b00;
                2: bad[7:6] = 2'b01;
                default: bad[7:6] = 2'b11;
            endcase
            seq_bytes[$urandom_range(1, n - 1)] = bad;
        end
        for (k = 0; k < stop; k++)
        begin
            if (stop < n)
                send_byte(seq_bytes[k], k == stop - 1);
            else if (k == n - 1)
                send_byte(seq_bytes[k], 1'($urandom));
            else
                send_byte(seq_bytes[k], 1'b0);
        end
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 12;
        recv_stall_pct = 71;
        requests_sent = 0;
        rst_n <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        byte_ch.last_byte <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFD, 1'b0);
        repeat (5) send_byte(8'hBF, 1'b0);
        // bad continuation, then zero continuation
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h00, 1'b0);
        // cut short on the lead, then mid-sequence
        send_byte(8'hF0, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        // last flag on a completing byte is harmless
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
        send_byte(8'h41, 1'b1);

        while (requests_sent < 310)
            send_random_sequence();
        send_idle_pct = 71;
        recv_stall_pct = 12;
        while (requests_sent < 590)
            send_random_sequence();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (requests_sent < 870)
            send_random_sequence();

        byte_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("utf8_byte_stream_decoder_tb: done, clean");
        else
            $display("utf8_byte_stream_decoder_tb: done, errors");
        $finish;
    end

    initial
    begin
        cp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (cp_ch.valid && cp_ch.ready)
                sb.check_point('{cp_ch.code_point, cp_ch.seq_length, cp_ch.decode_error});
            cp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < StallLimit)
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (cp_ch.valid && cp_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("utf8_byte_stream_decoder_tb: done, errors");
        $finish;
    end

endmodule
